/* src/afpe_pkg.sv */
package afpe_pkg;

   // Buffer size counts the two header positions ("AT").
   localparam int BUFFER_BYTES = 32;
   localparam int PAYLOAD_CAP  = BUFFER_BYTES - 2;
   localparam int CNT_W        = $clog2(PAYLOAD_CAP + 1);
   localparam int IDX_W        = $clog2(PAYLOAD_CAP);

   typedef logic [7:0]       byte_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;

   localparam cnt_type CAP_CNT = cnt_type'(PAYLOAD_CAP);

   localparam byte_type CH_A = 8'h41;
   localparam byte_type CH_T = 8'h54;
   localparam byte_type CH_Q = 8'h51;

   // Access to the payload store for one cycle.
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      byte_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } ram_req_type;

endpackage

/* src/afpe_if.sv */
interface afpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* src/at_frame_payload_echo.sv */
//  channel | dir | transfer carries        | notes
//  --------+-----+-------------------------+----------------------------------
//  req_bus | in  | rx_byte                 | one received character
//  rsp_bus | out | out_byte, last          | echoed payload, last on final byte
//
//  Header and payload bytes are taken one per cycle; req_bus.ready is high
//  whenever no echo is running.
//  A terminating 'Q' starts the echo: the first byte is fetched, then each
//  echoed byte takes a store read for lookahead, then the transfer, as set
//  by the single read port of the payload store. The final byte needs no
//  lookahead at the store end.
//  Reset (synchronous, active high) returns to hunting for 'A'; the store
//  needs no clearing, only entries written in the current frame are read.
//  A stalled rsp_bus holds the byte and last flag until taken; no input is
//  taken during the echo.
module at_frame_payload_echo
   import afpe_pkg::*;
(
   input logic         clock,
   input logic         reset,
   afpe_req_if.sink    req_bus,
   afpe_rsp_if.source  rsp_bus
);

   // Sequencer states
   localparam logic [2:0] ST_HUNT  = 3'd0;  // waiting for 'A'
   localparam logic [2:0] ST_GOT_A = 3'd1;  // 'A' seen, need 'T'
   localparam logic [2:0] ST_BODY  = 3'd2;  // storing payload until 'Q'
   localparam logic [2:0] ST_LOAD0 = 3'd3;  // first byte arriving from store
   localparam logic [2:0] ST_PEEK  = 3'd4;  // lookahead byte arriving
   localparam logic [2:0] ST_SHOW  = 3'd5;  // byte on rsp_bus

   logic [2:0]  state_ff, state_in;
   cnt_type     count_ff, count_in;    // payload bytes stored
   cnt_type     idx_ff,   idx_in;      // entry held by the lookahead read
   byte_type    cur_ff,   cur_in;      // byte being offered
   logic        last_ff,  last_in;

   ram_req_type ram_req;
   byte_type    rd_data;

   logic        req_xfer;
   logic        rsp_xfer;
   cnt_type     idx_inc;

   assign req_bus.ready = (state_ff == ST_HUNT) || (state_ff == ST_GOT_A)
                          || (state_ff == ST_BODY);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid    = (state_ff == ST_SHOW);
   assign rsp_bus.out_byte = cur_ff;
   assign rsp_bus.last     = last_ff;
   assign rsp_xfer         = rsp_bus.valid && rsp_bus.ready;

   assign idx_inc = idx_ff + cnt_type'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      last_in  = last_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = count_ff[IDX_W-1:0];
      ram_req.wr_data = req_bus.rx_byte;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = idx_inc[IDX_W-1:0];

      case (state_ff)
         ST_HUNT: begin
            if (req_xfer && (req_bus.rx_byte == CH_A)) begin
               state_in = ST_GOT_A;
            end
         end
         ST_GOT_A: begin
            // Anything but 'T' (an early 'Q' too) drops back to hunting.
            if (req_xfer) begin
               count_in = '0;
               state_in = (req_bus.rx_byte == CH_T) ? ST_BODY : ST_HUNT;
            end
         end
         ST_BODY: begin
            if (req_xfer) begin
               if (req_bus.rx_byte != CH_Q) begin
                  if (count_ff == CAP_CNT) begin
                     state_in = ST_HUNT;        // overflow: abandon frame
                  end else begin
                     ram_req.wr_en = 1'b1;
                     count_in      = count_ff + cnt_type'(1);
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_HUNT;           // empty payload
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = '0;
                  state_in        = ST_LOAD0;
               end
            end
         end
         ST_LOAD0: begin
            cur_in = rd_data;
            idx_in = cnt_type'(1);
            if (rd_data == '0) begin
               state_in = ST_HUNT;              // first byte zero: nothing
            end else if (count_ff == cnt_type'(1)) begin
               last_in  = 1'b1;
               state_in = ST_SHOW;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_type'(1);
               state_in        = ST_PEEK;
            end
         end
         ST_PEEK: begin
            // Next byte zero ends the echo at the current one.
            last_in  = (rd_data == '0);
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_xfer) begin
               if (last_ff) begin
                  state_in = ST_HUNT;
               end else begin
                  cur_in = rd_data;
                  if (idx_inc == count_ff) begin
                     last_in = 1'b1;            // store end reached
                  end else begin
                     ram_req.rd_en = 1'b1;
                     idx_in        = idx_inc;
                     state_in      = ST_PEEK;
                  end
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      last_ff  <= last_in;
   end

   afpe_ram u_store (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

endmodule

/* src/afpe_ram.sv */
module afpe_ram
   import afpe_pkg::*;
(
   input  logic        clock,
   input  ram_req_type req,
   output byte_type    rd_data
);

   byte_type mem [PAYLOAD_CAP];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/afpe_checker.sv */
module afpe_checker
   import afpe_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_out_byte,
   input logic     rsp_last
);

   // Stalled result holds still.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last))
      else $error("rsp changed while stalled");

   // No input taken while an echo is on offer.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready during echo");

   // Final byte of a frame ends the echo.
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("echo continued after last");

   // Out of reset the block is hunting and silent.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // An echo never starts without an input transfer.
   a_echo_cause : assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |=> !rsp_valid)
      else $error("echo started without input");

endmodule

bind at_frame_payload_echo afpe_checker u_afpe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_out_byte (rsp_bus.out_byte),
   .rsp_last     (rsp_bus.last)
);

/* tb/tb.sv */
module tb;
   import afpe_pkg::*;

   localparam int RAND_ITEMS  = 420;      // frame bytes in the random part
   localparam int CYCLE_LIMIT = 500000;   // far beyond the slowest legal run
   localparam int SETTLE      = 80;       // settle time after the last echo

   typedef struct {
      byte_type data;
      logic     last;
   } echo_item_type;

   // What the monitor should do with one input transfer: use the echo typed
   // into the directed table, or trust the frame tracker.
   typedef struct {
      bit    typed;
      string echo;
   } note_type;

   typedef struct {
      byte_type rx;
      bit       typed;
      string    echo;
   } dir_row_type;

   logic clock;
   logic reset;

   afpe_req_if req_bus ();
   afpe_rsp_if rsp_bus ();

   at_frame_payload_echo dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Frame tracker state, kept apart from the block's own.
   int            hdr_pos;               // 0 hunting, 1 awaiting 'T', 2+k k bytes held
   byte_type      payload_copy [PAYLOAD_CAP];
   byte_type      echo_bytes [$];        // bytes released by the latest 'Q'

   echo_item_type echo_due [$];          // echo transfers still owed by the block
   note_type      item_notes [$];        // one per presented input, in order

   bit            steady;                // no idling on either side while set
   int            n_err;
   int            n_in;
   int            n_out;
   int            n_frames;
   int            n_frame_items;
   int            n_cycles;
   int            stall_left;

   dir_row_type   dir_rows [28];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // Advance the tracked frame by one received byte; a 'Q' after "AT" fills
   // echo_bytes with the held payload up to the first zero.
   function void track_frame(input byte_type b);
      int stored;
      echo_bytes.delete();
      if (hdr_pos == 0) begin
         if (b == CH_A) hdr_pos = 1;
      end else if (hdr_pos == 1) begin
         // anything but 'T' drops back to hunting, itself not rechecked
         hdr_pos = (b == CH_T) ? 2 : 0;
      end else begin
         stored = hdr_pos - 2;
         if (b != CH_Q) begin
            if (stored >= PAYLOAD_CAP) begin
               hdr_pos = 0;                  // overflow: frame abandoned
            end else begin
               payload_copy[stored] = b;
               hdr_pos = stored + 3;
            end
         end else begin
            hdr_pos = 0;
            for (int i = 0; i < stored && payload_copy[i] != 8'h00; i++)
               echo_bytes.push_back(payload_copy[i]);
         end
      end
   endfunction

   // One input transfer; valid stays high into the next call unless a gap is
   // taken, so it is never dropped and raised in the same step.
   task automatic send_byte(input byte_type b, input bit typed = 1'b0,
                            input string echo = "");
      item_notes.push_back('{typed, echo});
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Hold the sender back until every owed echo has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (echo_due.size() != 0);
   endtask

   function automatic byte_type payload_byte();
      byte_type v;
      case ($urandom_range(0, 9))
         0:       v = CH_A;
         1:       v = CH_T;
         default: v = byte_type'($urandom_range(1, 255));
      endcase
      if (v == CH_Q) v = 8'hFF;           // keep the frame open
      return v;
   endfunction

   // Well-formed frame: "AT", plen payload bytes, 'Q'. Past PAYLOAD_CAP the
   // frame overflows and the closing 'Q' lands while hunting.
   task automatic send_frame(input int plen, input bit zeros_ok);
      int zero_at;
      zero_at = -1;
      if (zeros_ok && plen > 0 && $urandom_range(0, 5) == 0)
         zero_at = $urandom_range(0, plen - 1);
      send_byte(CH_A);
      send_byte(CH_T);
      for (int i = 0; i < plen; i++)
         send_byte((i == zero_at) ? 8'h00 : payload_byte());
      send_byte(CH_Q);
      n_frame_items += plen + 3;
   endtask

   // Junk between frames: stray bytes, broken headers, early 'Q'.
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_byte(byte_type'($urandom_range(0, 255)));
         1: begin
            send_byte(CH_A);
            send_byte(byte_type'($urandom_range(0, 255)));
         end
         2: begin
            send_byte(CH_A);
            send_byte(CH_Q);
         end
         default: begin
            send_byte(CH_A);
            send_byte(CH_A);
            send_byte(CH_T);
         end
      endcase
   endtask

   // Sink side: ready drops for random stretches, none while steady.
   initial begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Monitor: each input transfer feeds the tracker and queues its echo;
   // each echo transfer is matched against the oldest queued one.
   always @(posedge clock) begin : monitor
      note_type      note;
      echo_item_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            n_in++;
            note = item_notes.pop_front();
            track_frame(req_bus.rx_byte);
            if (note.typed) begin
               for (int k = 0; k < note.echo.len(); k++)
                  echo_due.push_back('{byte_type'(note.echo[k]), k == note.echo.len() - 1});
            end else begin
               foreach (echo_bytes[k])
                  echo_due.push_back('{echo_bytes[k], k == echo_bytes.size() - 1});
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            n_out++;
            if (echo_due.size() == 0) begin
               $error("unexpected echo transfer: out_byte %h last %b",
                      rsp_bus.out_byte, rsp_bus.last);
               n_err++;
            end else begin
               want = echo_due.pop_front();
               if (rsp_bus.out_byte !== want.data) begin
                  $error("out_byte: expected %h, got %h", want.data, rsp_bus.out_byte);
                  n_err++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_bus.last);
                  n_err++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      n_cycles = 0;
      while (n_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         n_cycles++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      int plen;

      hdr_pos         = 0;
      n_err           = 0;
      n_in            = 0;
      n_out           = 0;
      n_frames        = 0;
      n_frame_items   = 0;
      steady          = 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;

      // Typed echoes only where they are plain; the rest go to the tracker.
      dir_rows = '{
         '{CH_Q,  1'b1, ""},     // early 'Q' while hunting
         '{CH_A,  1'b0, ""},
         '{CH_Q,  1'b1, ""},     // early 'Q' while awaiting 'T'
         '{CH_A,  1'b0, ""},
         '{CH_A,  1'b0, ""},     // second 'A' is a wrong header byte...
         '{CH_T,  1'b0, ""},     // ...so this 'T' is ignored
         '{CH_A,  1'b0, ""},
         '{CH_T,  1'b0, ""},
         '{CH_Q,  1'b1, ""},     // empty payload
         '{CH_A,  1'b0, ""},
         '{CH_T,  1'b0, ""},
         '{8'h00, 1'b0, ""},
         '{8'h42, 1'b0, ""},
         '{CH_Q,  1'b1, ""},     // payload opens with zero
         '{CH_A,  1'b0, ""},
         '{CH_T,  1'b0, ""},
         '{8'h48, 1'b0, ""},
         '{8'h49, 1'b0, ""},
         '{8'h00, 1'b0, ""},
         '{8'h5A, 1'b0, ""},
         '{CH_Q,  1'b1, "HI"},   // zero inside payload cuts the echo
         '{CH_A,  1'b0, ""},
         '{CH_T,  1'b0, ""},
         '{8'hFF, 1'b0, ""},     // top byte and header letters as payload
         '{CH_A,  1'b0, ""},
         '{CH_T,  1'b0, ""},
         '{8'h01, 1'b0, ""},
         '{CH_Q,  1'b0, ""}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].echo);
      wait_drained();

      // Random frames: first a full store, then an overflow, then a mix
      // weighted to short payloads with some long ones.
      while (n_frame_items < RAND_ITEMS) begin
         steady = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 2) == 0) send_noise();
         case (n_frames)
            0: plen = PAYLOAD_CAP;
            1: plen = PAYLOAD_CAP + 1;
            default:
               case ($urandom_range(0, 19))
                  0:       plen = 0;
                  1:       plen = PAYLOAD_CAP;
                  2:       plen = $urandom_range(PAYLOAD_CAP + 1, PAYLOAD_CAP + 3);
                  3, 4, 5: plen = $urandom_range(9, PAYLOAD_CAP - 1);
                  default: plen = $urandom_range(1, 8);
               endcase
         endcase
         send_frame(plen, n_frames > 1);
         n_frames++;
         if (n_frames % 12 == 0) wait_drained();
      end

      steady = 1'b0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d input transfers (%0d random frames) and %0d echo transfers,",
               n_in, n_frames, n_out);
      $display("including full-store, overflow, zero-cut and broken-header frames.");
      if (n_err == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/afpe_pkg.sv
src/afpe_if.sv
src/afpe_ram.sv
src/at_frame_payload_echo.sv
src/afpe_checker.sv
tb/tb.sv
